### src/ukct_pkg.sv
// ----------------------------------------------------------------------------
// ukct_pkg
// Shared widths, request and status codes, and the cell command and chain
// link types of the compacting key table.
// ----------------------------------------------------------------------------
package ukct_pkg;

    localparam int KEY_W     = 32;
    localparam int POS_W     = 6;
    localparam int ACT_W     = 3;
    localparam int ST_W      = 3;
    localparam int CNT_OUT_W = 7;
    localparam int POS_SPAN  = 2 ** POS_W;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD    = 3'd0,
        ACT_SEEK   = 3'd1,
        ACT_REMOVE = 3'd2,
        ACT_GET    = 3'd3,
        ACT_CLEAR  = 3'd4
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK        = 3'd0,
        ST_ZERO_KEY  = 3'd1,
        ST_DUPLICATE = 3'd2,
        ST_FULL      = 3'd3,
        ST_NOT_FOUND = 3'd4,
        ST_RANGE     = 3'd5
    } t_status;

    typedef struct packed {
        logic match;
        logic shift;
        logic clear;
        logic add;
    } t_cell_cmd;

    typedef struct packed {
        logic             hit_seen;
        logic [POS_W-1:0] pos_acc;
        logic [KEY_W-1:0] val_acc;
    } t_link;

endpackage

### src/ukct_cell.sv
// ----------------------------------------------------------------------------
// ukct_cell
// One table slot. Holds a key, flags a key match or a position select, merges
// its answer into the chain link and takes its right neighbor's key on remove.
// ----------------------------------------------------------------------------
module ukct_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 7
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ukct_pkg::t_cell_cmd       i_cmd,
    input  logic [ukct_pkg::KEY_W-1:0] i_key,
    input  logic [ukct_pkg::POS_W-1:0] i_pos,
    input  logic [CNT_W-1:0]          i_count,
    input  logic [ukct_pkg::KEY_W-1:0] i_next_value,
    input  ukct_pkg::t_link           i_link,
    output ukct_pkg::t_link           o_link,
    output logic [ukct_pkg::KEY_W-1:0] o_value
);

    localparam logic [ukct_pkg::POS_W-1:0] IDX_POS = ukct_pkg::POS_W'(INDEX);
    localparam logic [CNT_W-1:0]          IDX_CNT = CNT_W'(INDEX);
    localparam bit                        SELECTABLE = (INDEX < ukct_pkg::POS_SPAN);

    logic [ukct_pkg::KEY_W-1:0] r_value;
    logic                       r_hit;
    logic                       r_sel;
    logic                       n_prefix;

    assign n_prefix        = i_link.hit_seen | r_hit;
    assign o_link.hit_seen = n_prefix;
    assign o_link.pos_acc  = i_link.pos_acc | (r_hit ? IDX_POS : '0);
    assign o_link.val_acc  = i_link.val_acc | (r_sel ? r_value : '0);
    assign o_value         = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= '0;
            r_hit   <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            if (i_cmd.match) begin
                r_hit <= (i_key != '0) && (r_value == i_key);
                r_sel <= SELECTABLE && (i_pos == IDX_POS);
            end
            priority if (i_cmd.clear) begin
                r_value <= '0;
            end else if (i_cmd.shift && n_prefix) begin
                r_value <= i_next_value;
            end else if (i_cmd.add && (i_count == IDX_CNT)) begin
                r_value <= i_key;
            end else begin
                r_value <= r_value;
            end
        end
    end

endmodule

### src/unique_key_compacting_table_core.sv
// ----------------------------------------------------------------------------
// unique_key_compacting_table_core
// Packed table of unique nonzero keys in insertion order, built as a row of
// slot cells. Add, seek, remove with compaction, get by index and clear.
//
//   channel | direction | handshake          | fields
//   --------+-----------+--------------------+------------------------------
//   request | in        | i_valid / o_ready  | action, key, position
//   result  | out       | o_valid / i_ready  | status, found_position,
//           |           |                    | read_value, entry_count
//
// A request passes capture, a compare in every cell, then the merge along the
// cell chain with the commit of the table update.
// One request is in flight at a time; o_ready is high in the capture state.
// A result waiting in the output register holds the commit until taken.
// Reset empties the table.
// ----------------------------------------------------------------------------
module unique_key_compacting_table_core #(
    parameter int CAPACITY = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [ukct_pkg::ACT_W-1:0]       i_action,
    input  logic [ukct_pkg::KEY_W-1:0]       i_key,
    input  logic [ukct_pkg::POS_W-1:0]       i_position,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [ukct_pkg::ST_W-1:0]        o_status,
    output logic [ukct_pkg::POS_W-1:0]       o_found_position,
    output logic [ukct_pkg::KEY_W-1:0]       o_read_value,
    output logic [ukct_pkg::CNT_OUT_W-1:0]   o_entry_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > ukct_pkg::POS_W) ? CNT_W : ukct_pkg::POS_W) + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC
    } t_state;

    t_state                          r_state;
    ukct_pkg::t_action               r_action;
    logic [ukct_pkg::KEY_W-1:0]      r_key;
    logic [ukct_pkg::POS_W-1:0]      r_pos;
    logic [CNT_W-1:0]                r_count;
    logic                            r_out_valid;
    logic [ukct_pkg::ST_W-1:0]       r_status;
    logic [ukct_pkg::POS_W-1:0]      r_fpos;
    logic [ukct_pkg::KEY_W-1:0]      r_rval;
    logic [ukct_pkg::CNT_OUT_W-1:0]  r_ent_cnt;

    ukct_pkg::t_cell_cmd             n_cmd;
    ukct_pkg::t_status               n_status;
    logic [ukct_pkg::POS_W-1:0]      n_fpos;
    logic [ukct_pkg::KEY_W-1:0]      n_rval;
    logic [CNT_W-1:0]                n_count;
    logic                            n_commit;
    logic                            n_any_hit;
    logic                            n_in_range;

    ukct_pkg::t_link                 w_link  [0:CAPACITY];
    logic [ukct_pkg::KEY_W-1:0]      w_value [0:CAPACITY-1];

    assign w_link[0] = '0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ukct_pkg::KEY_W-1:0] w_next;
        if (g == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_value[g+1];
        end
        ukct_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (n_cmd),
            .i_key        (r_key),
            .i_pos        (r_pos),
            .i_count      (r_count),
            .i_next_value (w_next),
            .i_link       (w_link[g]),
            .o_link       (w_link[g+1]),
            .o_value      (w_value[g])
        );
    end

    assign n_any_hit  = w_link[CAPACITY].hit_seen;
    assign n_in_range = CMP_W'(r_pos) < CMP_W'(r_count);
    assign n_commit   = (r_state == S_EXEC) && (!r_out_valid || i_ready);

    always_comb begin
        n_cmd       = '0;
        n_cmd.match = (r_state == S_MATCH);
        n_status    = ukct_pkg::ST_OK;
        n_fpos      = '0;
        n_rval      = '0;
        n_count     = r_count;
        unique case (r_action)
            ukct_pkg::ACT_ADD: begin
                priority if (r_key == '0) begin
                    n_status = ukct_pkg::ST_ZERO_KEY;
                end else if (n_any_hit) begin
                    n_status = ukct_pkg::ST_DUPLICATE;
                end else if (r_count == FULL_CNT) begin
                    n_status = ukct_pkg::ST_FULL;
                end else begin
                    n_cmd.add = n_commit;
                    n_count   = r_count + CNT_W'(1);
                end
            end
            ukct_pkg::ACT_SEEK: begin
                if (n_any_hit) begin
                    n_fpos = w_link[CAPACITY].pos_acc;
                end else begin
                    n_status = ukct_pkg::ST_NOT_FOUND;
                end
            end
            ukct_pkg::ACT_REMOVE: begin
                if (n_any_hit) begin
                    n_cmd.shift = n_commit;
                    n_count     = r_count - CNT_W'(1);
                end else begin
                    n_status = ukct_pkg::ST_NOT_FOUND;
                end
            end
            ukct_pkg::ACT_GET: begin
                if (n_in_range) begin
                    n_rval = w_link[CAPACITY].val_acc;
                end else begin
                    n_status = ukct_pkg::ST_RANGE;
                end
            end
            ukct_pkg::ACT_CLEAR: begin
                n_cmd.clear = n_commit;
                n_count     = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_action <= ukct_pkg::t_action'(i_action);
                        r_key    <= i_key;
                        r_pos    <= i_position;
                        r_state  <= S_MATCH;
                    end
                end
                S_MATCH: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (n_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (n_commit) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
                r_status    <= n_status;
                r_fpos      <= n_fpos;
                r_rval      <= n_rval;
                r_ent_cnt   <= ukct_pkg::CNT_OUT_W'(n_count);
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_found_position = r_fpos;
    assign o_read_value     = r_rval;
    assign o_entry_count    = r_ent_cnt;

endmodule

### src/ukct_checker.sv
// ----------------------------------------------------------------------------
// ukct_checker
// Port-level checks of the compacting key table, bound to the top level.
// ----------------------------------------------------------------------------
module ukct_checker #(
    parameter int CAPACITY = 64
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_valid,
    input logic                           o_ready,
    input logic                           o_valid,
    input logic                           i_ready,
    input logic [ukct_pkg::ST_W-1:0]      o_status,
    input logic [ukct_pkg::POS_W-1:0]     o_found_position,
    input logic [ukct_pkg::KEY_W-1:0]     o_read_value,
    input logic [ukct_pkg::CNT_OUT_W-1:0] o_entry_count
);

    localparam bit COUNT_FITS = (CAPACITY < 2 ** ukct_pkg::CNT_OUT_W);

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status)
            && $stable(o_read_value) && $stable(o_entry_count))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second request taken while one is in flight");

    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ukct_pkg::ST_OK)
            |-> (o_found_position == '0) && (o_read_value == '0))
        else $error("failed request carries position or value");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == ukct_pkg::ST_FULL) && COUNT_FITS
            |-> (o_entry_count == ukct_pkg::CNT_OUT_W'(CAPACITY)))
        else $error("full status with table not full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && COUNT_FITS |-> (o_entry_count <= ukct_pkg::CNT_OUT_W'(CAPACITY)))
        else $error("entry count beyond capacity");

endmodule

bind unique_key_compacting_table_core ukct_checker #(
    .CAPACITY (CAPACITY)
) u_ukct_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_status         (o_status),
    .o_found_position (o_found_position),
    .o_read_value     (o_read_value),
    .o_entry_count    (o_entry_count)
);
